@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

@@ rtl/dsp_pkg.sv @@
//------------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants of the shortest-path engine.
//------------------------------------------------------------------------------
`default_nettype none
package dsp_pkg;
    localparam int NODES_DEF       = 32;
    localparam int EDGES_DEF       = 256;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int DIST_W          = 24;
    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_SAT = {{(DIST_W-1){1'b1}}, 1'b0};

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_DROP   = 2'd1;
    localparam logic [1:0] ST_CLEAR  = 2'd2;
    localparam logic [1:0] ST_NODE   = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  src_node;
        logic [4:0]  dst_node;
        logic [15:0] edge_weight;
        logic [4:0]  start_node;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [4:0]        node;
        logic              present;
        logic              reachable;
        logic [DIST_W-1:0] distance;
        logic [4:0]        predecessor;
        logic              last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_SEL, S_SCAN, S_WAIT, S_EMIT
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic init;      // reset node state, latch start
        logic sel_step;  // examine next node in the minimum search
        logic sel_begin; // start a minimum search
        logic scan_begin;
        logic scan_step; // issue one edge read
        logic relax;     // evaluate edge read last cycle
        logic emit_begin;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic sel_last;   // search at final node
        logic sel_found;  // a node was selected
        logic scan_last;  // issuing the final edge read
        logic scan_empty; // no edges to scan
        logic emit_last;
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/dsp_ram.sv @@
//------------------------------------------------------------------------------
// dsp_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module dsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/dsp_ctrl.sv @@
//------------------------------------------------------------------------------
// dsp_ctrl
// Sequencer for the run command: init, minimum search, edge scan, emission.
//------------------------------------------------------------------------------
`default_nettype none
module dsp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_run,
    input  wire dsp_pkg::t_stat i_stat,
    output dsp_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    dsp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dsp_pkg::S_IDLE: if (i_run) n_state = dsp_pkg::S_INIT;
            dsp_pkg::S_INIT: n_state = dsp_pkg::S_SEL;
            dsp_pkg::S_SEL: begin
                if (i_stat.sel_last) begin
                    if (!i_stat.sel_found) begin
                        n_state = dsp_pkg::S_EMIT;
                    end else if (i_stat.scan_empty) begin
                        n_state = dsp_pkg::S_SEL;
                    end else begin
                        n_state = dsp_pkg::S_SCAN;
                    end
                end
            end
            dsp_pkg::S_SCAN: if (i_stat.scan_last) n_state = dsp_pkg::S_WAIT;
            dsp_pkg::S_WAIT: n_state = dsp_pkg::S_SEL;
            dsp_pkg::S_EMIT: if (i_stat.emit_last) n_state = dsp_pkg::S_IDLE;
            default: n_state = dsp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            dsp_pkg::S_IDLE: o_busy = 1'b0;
            dsp_pkg::S_INIT: o_cmd.sel_begin = 1'b1;
            dsp_pkg::S_SEL: begin
                o_cmd.sel_step = 1'b1;
                if (i_stat.sel_last) begin
                    if (!i_stat.sel_found) begin
                        o_cmd.emit_begin = 1'b1;
                    end else if (i_stat.scan_empty) begin
                        o_cmd.sel_begin = 1'b1;
                    end else begin
                        o_cmd.scan_begin = 1'b1;
                    end
                end
            end
            dsp_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.relax = 1'b1;
            end
            dsp_pkg::S_WAIT: begin
                o_cmd.relax = 1'b1;
                o_cmd.sel_begin = 1'b1;
            end
            dsp_pkg::S_EMIT: o_cmd.emit_step = 1'b1;
            default: o_busy = 1'b1;
        endcase
        o_cmd.init = (r_state == dsp_pkg::S_IDLE) && i_run;
    end
endmodule
`default_nettype wire

@@ rtl/dsp_datapath.sv @@
//------------------------------------------------------------------------------
// dsp_datapath
// Edge table, node state registers, minimum search, relaxation and result output.
//------------------------------------------------------------------------------
`default_nettype none
module dsp_datapath #(
    parameter int NODES       = dsp_pkg::NODES_DEF,
    parameter int EDGES       = dsp_pkg::EDGES_DEF,
    parameter int WEIGHT_BITS = dsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire dsp_pkg::t_in  i_item,
    input  wire dsp_pkg::t_cmd i_cmd,
    output dsp_pkg::t_stat     o_stat,
    output logic               o_valid,
    output dsp_pkg::t_out      o_result
);
    localparam int NW = $clog2(NODES);
    localparam int EW = $clog2(EDGES);
    localparam int CW = $clog2(EDGES + 1);
    localparam int TW = 2 * NW + WEIGHT_BITS;
    localparam int DW = dsp_pkg::DIST_W;

    logic [CW-1:0]    r_count;
    logic [NODES-1:0] r_present, r_done;
    logic [DW-1:0]    r_dist [NODES];
    logic [NW-1:0]    r_pred [NODES];
    logic [4:0]       r_start;
    logic [NW-1:0]    r_idx;       // search / emit index
    logic [NW:0]      r_best;      // NODES means none
    logic [DW-1:0]    r_bestd;
    logic [NW-1:0]    r_cur;
    logic [DW-1:0]    r_curd;
    logic [CW-1:0]    r_eptr;      // next edge read is r_eptr-1

    logic          wr;
    logic [TW-1:0] wdata, rdata;
    logic [EW-1:0] raddr;
    logic          add_ok;

    assign add_ok = (r_count < CW'(EDGES)) && (32'(i_item.src_node) < NODES)
                    && (32'(i_item.dst_node) < NODES);
    assign wr    = i_accept && i_item.command == dsp_pkg::CMD_ADD && add_ok;
    assign wdata = {i_item.src_node[NW-1:0], i_item.dst_node[NW-1:0],
                    i_item.edge_weight[WEIGHT_BITS-1:0]};
    assign raddr = EW'(r_eptr - CW'(1));

    dsp_ram #(.WIDTH(TW), .DEPTH(EDGES)) u_edges (
        .i_clk  (i_clk),
        .i_we   (wr),
        .i_waddr(r_count[EW-1:0]),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Relaxation of the edge read in the previous cycle.
    logic [NW-1:0]          e_src, e_dst;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [DW:0]            sum;
    logic [DW-1:0]          nd;
    logic                   r_rvalid;
    assign {e_src, e_dst, e_w} = rdata;
    assign sum = {1'b0, r_curd} + (DW+1)'(e_w);
    assign nd  = (sum > {1'b0, dsp_pkg::DIST_SAT}) ? dsp_pkg::DIST_SAT : sum[DW-1:0];

    // Minimum search candidate.
    logic cand;
    assign cand = !r_done[r_idx] && (r_dist[r_idx] < r_bestd);

    assign o_stat.sel_last   = (32'(r_idx) == NODES - 1);
    assign o_stat.sel_found  = cand || !r_best[NW];
    assign o_stat.scan_last  = (r_eptr == CW'(1));
    assign o_stat.scan_empty = (r_count == '0);
    assign o_stat.emit_last  = (32'(r_idx) == NODES - 1);

    logic [NW-1:0] sel_node;
    logic [DW-1:0] sel_d;
    assign sel_node = cand ? r_idx : r_best[NW-1:0];
    assign sel_d    = cand ? r_dist[r_idx] : r_bestd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_present <= '0;
            r_done    <= '0;
            r_rvalid  <= 1'b0;
            o_valid   <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_dist[i] <= dsp_pkg::DIST_INF;
                r_pred[i] <= '0;
            end
        end else begin
            o_valid  <= 1'b0;
            r_rvalid <= i_cmd.scan_step;
            if (i_accept && i_item.command == dsp_pkg::CMD_CLEAR) begin
                r_count   <= '0;
                r_present <= '0;
                o_valid   <= 1'b1;
                o_result  <= '{status: dsp_pkg::ST_CLEAR, last: 1'b1, default: '0};
            end
            if (i_accept && i_item.command == dsp_pkg::CMD_ADD) begin
                o_valid  <= 1'b1;
                o_result <= '{status: add_ok ? dsp_pkg::ST_ACCEPT : dsp_pkg::ST_DROP,
                              last: 1'b1, default: '0};
                if (add_ok) begin
                    r_count <= r_count + CW'(1);
                    r_present[i_item.src_node[NW-1:0]] <= 1'b1;
                    r_present[i_item.dst_node[NW-1:0]] <= 1'b1;
                end
            end
            if (i_cmd.init) begin
                r_start <= i_item.start_node;
                r_done  <= '0;
                for (int i = 0; i < NODES; i++) begin
                    r_dist[i] <= (32'(i_item.start_node) == i) ? '0 : dsp_pkg::DIST_INF;
                    r_pred[i] <= '0;
                end
            end
            if (i_cmd.sel_step) begin
                r_idx <= r_idx + NW'(1);
                if (cand) begin
                    r_best  <= {1'b0, r_idx};
                    r_bestd <= r_dist[r_idx];
                end
                if (o_stat.sel_last && o_stat.sel_found) begin
                    r_done[sel_node] <= 1'b1;
                    r_cur  <= sel_node;
                    r_curd <= sel_d;
                end
            end
            if (i_cmd.scan_begin) begin
                r_eptr <= r_count;
            end
            if (i_cmd.scan_step) begin
                r_eptr <= r_eptr - CW'(1);
            end
            if (i_cmd.relax && r_rvalid && e_src == r_cur && nd < r_dist[e_dst]) begin
                r_dist[e_dst] <= nd;
                r_pred[e_dst] <= r_cur;
            end
            if (i_cmd.sel_begin) begin
                r_idx   <= '0;
                r_best  <= {1'b1, NW'(0)};
                r_bestd <= dsp_pkg::DIST_INF;
            end
            if (i_cmd.emit_begin) begin
                r_idx <= '0;
            end
            if (i_cmd.emit_step) begin
                o_valid <= 1'b1;
                o_result.status      <= dsp_pkg::ST_NODE;
                o_result.node        <= 5'(r_idx);
                o_result.present     <= r_present[r_idx] || (5'(r_idx) == r_start);
                o_result.reachable   <= r_dist[r_idx] != dsp_pkg::DIST_INF;
                o_result.distance    <= (r_dist[r_idx] != dsp_pkg::DIST_INF)
                                        ? r_dist[r_idx] : '0;
                o_result.predecessor <= (r_dist[r_idx] != dsp_pkg::DIST_INF)
                                        ? 5'(r_pred[r_idx]) : '0;
                o_result.last        <= o_stat.emit_last;
                r_idx <= r_idx + NW'(1);
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/dijkstra_shortest_path_top.sv @@
//------------------------------------------------------------------------------
// dijkstra_shortest_path_top
// Single-source shortest paths over a loaded edge table.
//------------------------------------------------------------------------------
// Clear and add-edge transactions give one result in the next cycle; a new one
// may follow every cycle while busy is low. A run raises busy in an init state,
// then a sequencer performs one linear minimum search over the nodes per
// settled node, each followed by a scan of the whole edge table through the
// single RAM read port (skipped when the table is empty), and a final search
// that finds no node. It then emits NODES records on consecutive cycles; busy
// drops as the last one is strobed. Results must be taken when strobed.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dijkstra_shortest_path_top #(
    parameter int NODES       = dsp_pkg::NODES_DEF,
    parameter int EDGES       = dsp_pkg::EDGES_DEF,
    parameter int WEIGHT_BITS = dsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire dsp_pkg::t_in i_item,
    output logic              o_valid,
    output dsp_pkg::t_out     o_result
);
    dsp_pkg::t_cmd  cmd;
    dsp_pkg::t_stat stat;
    logic           accept, run;

    assign accept = start && !busy;
    assign run    = accept && i_item.command == dsp_pkg::CMD_RUN;

    dsp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_run(run),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    dsp_datapath #(.NODES(NODES), .EDGES(EDGES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_item(i_item),
        .i_cmd(cmd), .o_stat(stat), .o_valid(o_valid), .o_result(o_result)
    );

    `ASSERT_NEXT(a_clear_result, i_clk, i_rst_n,
        accept && i_item.command == dsp_pkg::CMD_CLEAR,
        o_valid && o_result.status == dsp_pkg::ST_CLEAR, "clear gave no result")
    `ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, run, busy, "run did not raise busy")
    `ASSERT_IMPLY(a_last_idle, i_clk, i_rst_n,
        o_valid && o_result.status == dsp_pkg::ST_NODE && o_result.last,
        !busy, "last record while busy")
endmodule
`default_nettype wire

@@ verif/tb.sv @@
//------------------------------------------------------------------------------
// Shortest-path engine testbench
// Drives clear, add-edge, run and unknown commands and checks every strobed
// result against a behavioral shortest-path predictor kept in a scoreboard.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int NN = dsp_pkg::NODES_DEF;
    localparam int NE = dsp_pkg::EDGES_DEF;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    class path_scoreboard;
        logic [4:0]     edge_src[NE];
        logic [4:0]     edge_dst[NE];
        logic [15:0]    edge_wt[NE];
        int             edge_total;
        bit             on_graph[NN];
        dsp_pkg::t_out  pending[$];
        int             mismatches;

        function void clear_graph();
            edge_total = 0;
            foreach (on_graph[i]) on_graph[i] = 0;
        endfunction

        function void push_status(logic [1:0] st);
            dsp_pkg::t_out r;
            r = '0;
            r.status = st;
            r.last = 1'b1;
            pending.push_back(r);
        endfunction

        function void solve_from(logic [4:0] root);
            logic [dsp_pkg::DIST_W-1:0] path_cost[NN];
            logic [4:0]                 prev[NN];
            bit                         settled[NN];
            int                         pick;
            logic [dsp_pkg::DIST_W-1:0] pick_d;
            logic [dsp_pkg::DIST_W:0]   cand;
            dsp_pkg::t_out              r;
            foreach (path_cost[i]) begin
                path_cost[i] = dsp_pkg::DIST_INF;
                prev[i] = '0;
                settled[i] = 0;
            end
            path_cost[root] = '0;
            forever begin
                pick = NN;
                pick_d = dsp_pkg::DIST_INF;
                for (int i = 0; i < NN; i++)
                    if (!settled[i] && path_cost[i] < pick_d) begin
                        pick_d = path_cost[i];
                        pick = i;
                    end
                if (pick == NN) break;
                settled[pick] = 1;
                // Latest edges first, so ties keep the newest predecessor.
                for (int e = edge_total - 1; e >= 0; e--) begin
                    if (edge_src[e] != pick) continue;
                    cand = {1'b0, pick_d} + edge_wt[e];
                    if (cand > dsp_pkg::DIST_SAT) cand = dsp_pkg::DIST_SAT;
                    if (cand[dsp_pkg::DIST_W-1:0] < path_cost[edge_dst[e]]) begin
                        path_cost[edge_dst[e]] = cand[dsp_pkg::DIST_W-1:0];
                        prev[edge_dst[e]] = pick[4:0];
                    end
                end
            end
            for (int i = 0; i < NN; i++) begin
                r = '0;
                r.status = dsp_pkg::ST_NODE;
                r.node = i[4:0];
                r.present = on_graph[i] || i == root;
                r.reachable = path_cost[i] != dsp_pkg::DIST_INF;
                r.distance = r.reachable ? path_cost[i] : '0;
                r.predecessor = r.reachable ? prev[i] : '0;
                r.last = i == NN - 1;
                pending.push_back(r);
            end
        endfunction

        function void note_item(dsp_pkg::t_in it);
            case (it.command)
                dsp_pkg::CMD_CLEAR: begin
                    clear_graph();
                    push_status(dsp_pkg::ST_CLEAR);
                end
                dsp_pkg::CMD_ADD: begin
                    if (edge_total >= NE) begin
                        push_status(dsp_pkg::ST_DROP);
                    end else begin
                        edge_src[edge_total] = it.src_node;
                        edge_dst[edge_total] = it.dst_node;
                        edge_wt[edge_total] = it.edge_weight;
                        edge_total++;
                        on_graph[it.src_node] = 1;
                        on_graph[it.dst_node] = 1;
                        push_status(dsp_pkg::ST_ACCEPT);
                    end
                end
                dsp_pkg::CMD_RUN: solve_from(it.start_node);
                default: ;
            endcase
        endfunction

        function void check_result(dsp_pkg::t_out got);
            dsp_pkg::t_out want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status || got.node != want.node ||
                got.present != want.present || got.reachable != want.reachable ||
                got.distance != want.distance || got.predecessor != want.predecessor ||
                got.last != want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    dsp_pkg::t_in  i_item;
    logic          o_valid;
    dsp_pkg::t_out o_result;

    path_scoreboard sb;
    int burst_left;

    dijkstra_shortest_path_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    // Presents one transaction, idling first when the current burst is spent.
    task automatic send_item(dsp_pkg::t_in it);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic dsp_pkg::t_in make_item(logic [1:0] cmd, int s, int d, int w,
                                                int st);
        dsp_pkg::t_in it;
        it.command = cmd;
        it.src_node = s[4:0];
        it.dst_node = d[4:0];
        it.edge_weight = w[15:0];
        it.start_node = st[4:0];
        return it;
    endfunction

    function automatic dsp_pkg::t_in random_item();
        int pick;
        int wt;
        pick = $urandom_range(0, 99);
        wt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 20);
        if (pick < 75)
            return make_item(dsp_pkg::CMD_ADD, $urandom_range(0, 7), $urandom_range(0, 7),
                             wt, $urandom_range(0, 31));
        if (pick < 80)
            return make_item(dsp_pkg::CMD_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                             wt, $urandom_range(0, 31));
        if (pick < 92)
            return make_item(dsp_pkg::CMD_RUN, $urandom, $urandom, $urandom,
                             $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                       : $urandom_range(0, 7));
        if (pick < 96)
            return make_item(dsp_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        return make_item(CMD_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
    endfunction

    initial begin
        sb = new();
        sb.clear_graph();
        sb.mismatches = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme weights and nodes, ties, unknown command.
        send_item(make_item(dsp_pkg::CMD_RUN, 0, 0, 0, 0));
        send_item(make_item(dsp_pkg::CMD_ADD, 0, 31, 16'hFFFF, 0));
        send_item(make_item(dsp_pkg::CMD_ADD, 31, 1, 16'hFFFF, 0));
        send_item(make_item(dsp_pkg::CMD_ADD, 0, 1, 0, 0));
        send_item(make_item(dsp_pkg::CMD_ADD, 1, 2, 5, 0));
        send_item(make_item(dsp_pkg::CMD_ADD, 0, 2, 5, 0));
        send_item(make_item(dsp_pkg::CMD_ADD, 2, 2, 3, 0));
        send_item(make_item(CMD_UNKNOWN, 31, 31, 16'hFFFF, 31));
        send_item(make_item(dsp_pkg::CMD_RUN, 31, 31, 16'hFFFF, 0));
        send_item(make_item(dsp_pkg::CMD_RUN, 0, 0, 0, 31));
        send_item(make_item(dsp_pkg::CMD_RUN, 0, 0, 0, 17));
        wait_drained();
        send_item(make_item(dsp_pkg::CMD_CLEAR, 31, 31, 16'hFFFF, 31));
        // A long chain of maximum weights drives distances to large values, below saturation.
        for (int i = 0; i < 31; i++)
            send_item(make_item(dsp_pkg::CMD_ADD, i, i + 1, 16'hFFFF, 0));
        send_item(make_item(dsp_pkg::CMD_RUN, 0, 0, 0, 0));
        send_item(make_item(dsp_pkg::CMD_CLEAR, 0, 0, 0, 0));

        for (int n = 0; n < 130; n++) begin
            send_item(random_item());
            if (n == 65) wait_drained();
        end

        send_item(make_item(dsp_pkg::CMD_RUN, 0, 0, 0, $urandom_range(0, 31)));

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
